>>> src/fastq_fasta_record_parser_core_assert.svh
// assertion macros for the record parser
`ifndef FASTQ_FASTA_RECORD_PARSER_CORE_ASSERT_SVH
`define FASTQ_FASTA_RECORD_PARSER_CORE_ASSERT_SVH

// checked on every clock edge outside reset
`define FFRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define FFRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> src/ffrp_pkg.sv
`default_nettype none

package ffrp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } ffrp_in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       with_quality;
        logic       last;
    } ffrp_out_t;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_ID,
        PH_HDR_REST,
        PH_SEQ,
        PH_SEP_START,
        PH_SEP_REST,
        PH_QUAL,
        PH_HALT
    } phase_t;

    localparam logic [2:0] KIND_ID   = 3'd0;
    localparam logic [2:0] KIND_SEQ  = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_BAD  = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int MAX_RES = 3;

    function automatic ffrp_out_t make_res(logic [2:0] kind, logic [7:0] value, logic wq);
        ffrp_out_t r;
        r.kind         = kind;
        r.value        = value;
        r.with_quality = wq;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fastq_fasta_record_parser_core.sv
// an accepted byte's results are registered as the current bundle, or as the waiting one
// while the current bundle is still offered; throughput: one byte per cycle while each
// byte yields at most one result and m_ready is high; extra results hold the port until taken
// a two-slot result buffer (current bundle plus one waiting bundle) decouples the sides
// reset: synchronous active-low aresetn returns the parser to seeking a header
// and empties both result slots
`default_nettype none

`include "fastq_fasta_record_parser_core_assert.svh"

module fastq_fasta_record_parser_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ffrp_pkg::ffrp_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ffrp_pkg::ffrp_out_t      m_data
);
    import ffrp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       crh_reg, crh_next;
    logic       fq_reg, fq_next;
    logic       lhb_reg, lhb_next;

    ffrp_out_t  out_res_reg [MAX_RES];
    ffrp_out_t  out_res_next [MAX_RES];
    logic [1:0] out_n_reg, out_n_next;
    logic [1:0] out_idx_reg, out_idx_next;
    ffrp_out_t  pend_res_reg [MAX_RES];
    ffrp_out_t  pend_res_next [MAX_RES];
    logic [1:0] pend_n_reg, pend_n_next;

    ffrp_out_t  step_res [MAX_RES];
    logic [1:0] step_cnt;

    logic       accept;
    logic       fire;
    logic       out_last_one;
    logic       out_free;

    // parser step
    always_comb begin
        logic [7:0] b;
        logic       wq;
        logic       lhb_v;
        logic [2:0] k;
        b          = s_data.data_byte;
        wq         = fq_reg;
        lhb_v      = lhb_reg;
        k          = KIND_ID;
        phase_next = phase_reg;
        crh_next   = crh_reg;
        fq_next    = fq_reg;
        lhb_next   = lhb_reg;
        step_cnt   = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            step_res[i] = '0;
        end
        if (s_data.end_of_stream) begin
            unique case (phase_reg)
                PH_SEEK, PH_SEP_START: begin
                    if (crh_reg) begin
                        step_res[step_cnt] = make_res(KIND_BAD, 8'd0, wq);
                        step_cnt = step_cnt + 2'd1;
                    end
                end
                PH_ID: begin
                    if (crh_reg) begin
                        step_res[step_cnt] = make_res(KIND_ID, CH_CR, wq);
                        step_cnt = step_cnt + 2'd1;
                    end
                end
                PH_SEQ: begin
                    if (crh_reg) begin
                        step_res[step_cnt] = make_res(KIND_SEQ, CH_CR, wq);
                        step_cnt = step_cnt + 2'd1;
                        lhb_v = 1'b1;
                    end
                    if (lhb_v && !fq_reg) begin
                        step_res[step_cnt] = make_res(KIND_DONE, 8'd0, wq);
                        step_cnt = step_cnt + 2'd1;
                    end
                end
                PH_QUAL: begin
                    if (lhb_reg) begin
                        step_res[step_cnt] = make_res(KIND_DONE, 8'd0, wq);
                        step_cnt = step_cnt + 2'd1;
                    end
                end
                default: begin
                end
            endcase
            step_res[step_cnt] = make_res(KIND_END, 8'd0, 1'b0);
            step_cnt   = step_cnt + 2'd1;
            phase_next = PH_SEEK;
            crh_next   = 1'b0;
            fq_next    = 1'b0;
            lhb_next   = 1'b0;
        end else begin
            unique case (phase_reg)
                PH_SEEK: begin
                    if (crh_reg) begin
                        crh_next = 1'b0;
                        if (b != CH_LF) begin
                            step_res[step_cnt] = make_res(KIND_BAD, 8'd0, fq_reg);
                            step_cnt   = step_cnt + 2'd1;
                            phase_next = PH_HALT;
                        end
                    end else if (b == CH_CR) begin
                        crh_next = 1'b1;
                    end else if (b == CH_AT || b == CH_GT) begin
                        fq_next    = (b == CH_AT);
                        phase_next = PH_ID;
                    end else if (b != CH_LF) begin
                        fq_next = 1'b0;
                        step_res[step_cnt] = make_res(KIND_BAD, 8'd0, 1'b0);
                        step_cnt   = step_cnt + 2'd1;
                        phase_next = PH_HALT;
                    end
                end
                PH_ID, PH_SEQ: begin
                    k = (phase_reg == PH_ID) ? KIND_ID : KIND_SEQ;
                    if (crh_reg) begin
                        crh_next = 1'b0;
                        if (b != CH_LF) begin
                            step_res[step_cnt] = make_res(k, CH_CR, wq);
                            step_cnt = step_cnt + 2'd1;
                            lhb_next = 1'b1;
                        end
                    end
                    if (b == CH_LF) begin
                        lhb_next = 1'b0;
                        if (phase_reg == PH_ID) begin
                            phase_next = PH_SEQ;
                        end else if (fq_reg) begin
                            phase_next = PH_SEP_START;
                        end else begin
                            step_res[step_cnt] = make_res(KIND_DONE, 8'd0, wq);
                            step_cnt   = step_cnt + 2'd1;
                            fq_next    = 1'b0;
                            phase_next = PH_SEEK;
                        end
                    end else if (b == CH_CR) begin
                        crh_next = 1'b1;
                    end else if (phase_reg == PH_ID && (b == CH_SPACE || b == CH_TAB)) begin
                        phase_next = PH_HDR_REST;
                    end else begin
                        step_res[step_cnt] = make_res(k, b, wq);
                        step_cnt = step_cnt + 2'd1;
                        lhb_next = 1'b1;
                    end
                end
                PH_HDR_REST: begin
                    if (b == CH_LF) begin
                        lhb_next   = 1'b0;
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEP_START: begin
                    if (crh_reg) begin
                        step_res[step_cnt] = make_res(KIND_BAD, 8'd0, wq);
                        step_cnt   = step_cnt + 2'd1;
                        crh_next   = 1'b0;
                        phase_next = PH_HALT;
                    end else if (b == CH_PLUS) begin
                        phase_next = PH_SEP_REST;
                    end else if (b == CH_CR) begin
                        crh_next = 1'b1;
                    end else begin
                        step_res[step_cnt] = make_res(KIND_BAD, 8'd0, wq);
                        step_cnt   = step_cnt + 2'd1;
                        phase_next = PH_HALT;
                    end
                end
                PH_SEP_REST: begin
                    if (b == CH_LF) begin
                        lhb_next   = 1'b0;
                        phase_next = PH_QUAL;
                    end
                end
                PH_QUAL: begin
                    if (b == CH_LF) begin
                        step_res[step_cnt] = make_res(KIND_DONE, 8'd0, wq);
                        step_cnt   = step_cnt + 2'd1;
                        fq_next    = 1'b0;
                        lhb_next   = 1'b0;
                        phase_next = PH_SEEK;
                    end else begin
                        lhb_next = 1'b1;
                    end
                end
                PH_HALT: begin
                    crh_next = 1'b0;
                end
                default: begin
                    phase_next = PH_HALT;
                    crh_next   = 1'b0;
                end
            endcase
        end
        if (step_cnt != 2'd0) begin
            step_res[step_cnt - 2'd1].last = 1'b1;
        end
    end

    // result buffer control
    assign s_ready      = (pend_n_reg == 2'd0);
    assign accept       = s_valid && s_ready;
    assign m_valid      = (out_n_reg != 2'd0);
    assign m_data       = out_res_reg[out_idx_reg];
    assign fire         = m_valid && m_ready;
    assign out_last_one = (out_idx_reg == out_n_reg - 2'd1);
    assign out_free     = (out_n_reg == 2'd0) || (fire && out_last_one);

    always_comb begin
        out_res_next  = out_res_reg;
        out_n_next    = out_n_reg;
        out_idx_next  = out_idx_reg;
        pend_res_next = pend_res_reg;
        pend_n_next   = pend_n_reg;
        if (fire && !out_last_one) begin
            out_idx_next = out_idx_reg + 2'd1;
        end
        if (out_free) begin
            out_idx_next = 2'd0;
            if (pend_n_reg != 2'd0) begin
                out_res_next = pend_res_reg;
                out_n_next   = pend_n_reg;
                pend_n_next  = 2'd0;
            end else if (accept && step_cnt != 2'd0) begin
                out_res_next = step_res;
                out_n_next   = step_cnt;
            end else begin
                out_n_next = 2'd0;
            end
        end else if (accept && step_cnt != 2'd0) begin
            pend_res_next = step_res;
            pend_n_next   = step_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEEK;
            crh_reg     <= 1'b0;
            fq_reg      <= 1'b0;
            lhb_reg     <= 1'b0;
            out_n_reg   <= 2'd0;
            out_idx_reg <= 2'd0;
            pend_n_reg  <= 2'd0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                crh_reg   <= crh_next;
                fq_reg    <= fq_next;
                lhb_reg   <= lhb_next;
            end
            out_n_reg   <= out_n_next;
            out_idx_reg <= out_idx_next;
            pend_n_reg  <= pend_n_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        pend_res_reg <= pend_res_next;
    end

    `FFRP_ASSERT(a_pend_behind_out, (pend_n_reg != 2'd0) |-> (out_n_reg != 2'd0), "waiting bundle without current bundle")
    `FFRP_ASSERT(a_idx_in_range, (out_n_reg != 2'd0) |-> (out_idx_reg < out_n_reg), "result index past bundle end")
    `FFRP_ASSERT(a_last_marks_end, (m_valid && out_last_one) |-> m_data.last, "final result of a byte lacks last")
    `FFRP_ASSERT_ALWAYS(a_halt_no_cr, (phase_reg == PH_HALT) |-> !crh_reg, "carriage return held while halted")

endmodule

`default_nettype wire

>>> tb/sv/ffrp_record_check.sv
`default_nettype none

module ffrp_record_check (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire ffrp_pkg::ffrp_in_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire ffrp_pkg::ffrp_out_t m_data,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ffrp_pkg::*;

    phase_t    parse_phase;
    logic      cr_pending;
    logic      fastq_rec;
    logic      line_nonempty;
    ffrp_out_t parsed_results[$];
    ffrp_out_t byte_results[$];
    int        errs = 0;

    task automatic clear_parser();
        parse_phase   = PH_SEEK;
        cr_pending    = 1'b0;
        fastq_rec     = 1'b0;
        line_nonempty = 1'b0;
    endtask

    task automatic push_result(input logic [2:0] kind, input logic [7:0] value, input logic wq);
        ffrp_out_t r;
        r.kind         = kind;
        r.value        = value;
        r.with_quality = wq;
        r.last         = 1'b0;
        byte_results.push_back(r);
    endtask

    task automatic flag_malformed();
        push_result(KIND_BAD, 8'h00, fastq_rec);
        cr_pending  = 1'b0;
        parse_phase = PH_HALT;
    endtask

    task automatic close_record();
        push_result(KIND_DONE, 8'h00, fastq_rec);
        fastq_rec     = 1'b0;
        line_nonempty = 1'b0;
        parse_phase   = PH_SEEK;
    endtask

    // a held cr counts as data of an unfinished id or sequence line, but is malformed before a header or separator
    task automatic finish_stream();
        case (parse_phase)
            PH_SEEK, PH_SEP_START: begin
                if (cr_pending) flag_malformed();
            end
            PH_ID: begin
                if (cr_pending) push_result(KIND_ID, CH_CR, fastq_rec);
            end
            PH_SEQ: begin
                if (cr_pending) begin
                    push_result(KIND_SEQ, CH_CR, fastq_rec);
                    line_nonempty = 1'b1;
                end
                if (line_nonempty && !fastq_rec) close_record();
            end
            PH_QUAL: begin
                if (line_nonempty) close_record();
            end
            default: ;
        endcase
        push_result(KIND_END, 8'h00, 1'b0);
        clear_parser();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic       wq;
        logic [2:0] k;
        wq = fastq_rec;
        k  = (parse_phase == PH_ID) ? KIND_ID : KIND_SEQ;
        case (parse_phase)
            PH_SEEK: begin
                if (cr_pending) begin
                    cr_pending = 1'b0;
                    if (b != CH_LF) flag_malformed();
                end else if (b == CH_CR) begin
                    cr_pending = 1'b1;
                end else if (b == CH_AT || b == CH_GT) begin
                    fastq_rec   = (b == CH_AT);
                    parse_phase = PH_ID;
                end else if (b != CH_LF) begin
                    fastq_rec = 1'b0;
                    flag_malformed();
                end
            end
            PH_ID, PH_SEQ: begin
                if (cr_pending) begin
                    cr_pending = 1'b0;
                    if (b != CH_LF) begin
                        push_result(k, CH_CR, wq);
                        line_nonempty = 1'b1;
                    end
                end
                if (b == CH_LF) begin
                    line_nonempty = 1'b0;
                    if (parse_phase == PH_ID) parse_phase = PH_SEQ;
                    else if (fastq_rec) parse_phase = PH_SEP_START;
                    else close_record();
                end else if (b == CH_CR) begin
                    cr_pending = 1'b1;
                end else if (parse_phase == PH_ID && (b == CH_SPACE || b == CH_TAB)) begin
                    parse_phase = PH_HDR_REST;
                end else begin
                    push_result(k, b, wq);
                    line_nonempty = 1'b1;
                end
            end
            PH_HDR_REST: begin
                if (b == CH_LF) begin
                    line_nonempty = 1'b0;
                    parse_phase   = PH_SEQ;
                end
            end
            PH_SEP_START: begin
                if (cr_pending) flag_malformed();
                else if (b == CH_PLUS) parse_phase = PH_SEP_REST;
                else if (b == CH_CR) cr_pending = 1'b1;
                else flag_malformed();
            end
            PH_SEP_REST: begin
                if (b == CH_LF) begin
                    line_nonempty = 1'b0;
                    parse_phase   = PH_QUAL;
                end
            end
            PH_QUAL: begin
                if (b == CH_LF) close_record();
                else line_nonempty = 1'b1;
            end
            default: begin
                parse_phase = PH_HALT;
                cr_pending  = 1'b0;
            end
        endcase
    endtask

    task automatic predict_request(input ffrp_in_t req);
        byte_results.delete();
        if (req.end_of_stream) finish_stream();
        else parse_byte(req.data_byte);
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i]) parsed_results.push_back(byte_results[i]);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errs++;
    endtask

    task automatic check_result(input ffrp_out_t got);
        ffrp_out_t want;
        if (parsed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %02h",
                                      got.kind, got.value));
            return;
        end
        want = parsed_results.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.value != want.value)
            report_mismatch($sformatf("value %02h, want %02h", got.value, want.value));
        if (got.with_quality != want.with_quality)
            report_mismatch($sformatf("with_quality %0b, want %0b",
                                      got.with_quality, want.with_quality));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            parsed_results.delete();
        end else begin
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) predict_request(s_data);
        end
        mismatches  <= errs;
        outstanding <= parsed_results.size();
    end

endmodule

`default_nettype wire

>>> tb/sv/fastq_fasta_record_parser_core_tb.sv
`default_nettype none

module fastq_fasta_record_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffrp_pkg::*;

    localparam int STREAM_LEN   = 460;
    localparam int LIMIT        = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 30;
    localparam int DRAIN_CYCLES = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    ffrp_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    ffrp_out_t m_data;
    int        mismatches;
    int        outstanding;

    ffrp_in_t  text_stream[$];
    int        stall_pct     = 0;
    int        seen_requests = 0;
    int        hold_left     = 0;
    bit        hold_done     = 1'b0;
    int        cycles        = 0;

    always #6 aclk = ~aclk;

    fastq_fasta_record_parser_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ffrp_record_check record_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic push_byte(input logic [7:0] b);
        ffrp_in_t r;
        r.data_byte     = b;
        r.end_of_stream = 1'b0;
        text_stream.push_back(r);
    endtask

    task automatic push_eos();
        ffrp_in_t r;
        r.data_byte     = 8'($urandom_range(255));
        r.end_of_stream = 1'b1;
        text_stream.push_back(r);
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] id_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b inside {CH_LF, CH_CR, CH_SPACE, CH_TAB});
        return b;
    endfunction

    task automatic line_end();
        if ($urandom_range(3) == 0) push_byte(CH_CR);
        push_byte(CH_LF);
    endtask

    task automatic add_record(input bit bad_sep);
        bit         fq;
        logic [7:0] b;
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(1)) push_byte(CH_CR);
            push_byte(CH_LF);
        end
        fq = 1'($urandom_range(1));
        push_byte(fq ? CH_AT : CH_GT);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(7) == 0) push_byte(CH_CR);
            push_byte(id_byte());
        end
        if ($urandom_range(2) == 0) begin
            push_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
            repeat ($urandom_range(0, 3)) push_byte(any_but_lf());
        end
        line_end();
        repeat ($urandom_range(0, 8)) push_byte(any_but_lf());
        line_end();
        if (fq) begin
            if (bad_sep) begin
                if ($urandom_range(1)) begin
                    push_byte(CH_CR);
                    push_byte(any_but_lf());
                end else begin
                    do b = 8'($urandom_range(255)); while (b == CH_PLUS || b == CH_CR);
                    push_byte(b);
                end
            end else begin
                push_byte(CH_PLUS);
                repeat ($urandom_range(0, 3)) push_byte(any_but_lf());
                line_end();
                repeat ($urandom_range(0, 6)) push_byte(any_but_lf());
                line_end();
            end
        end
    endtask

    // well-formed records, then now and then a broken tail
    task automatic add_stream();
        int         start;
        int         cut;
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) add_record(1'b0);
        case ($urandom_range(9))
            0: begin
                do b = 8'($urandom_range(255)); while (b inside {CH_AT, CH_GT, CH_LF, CH_CR});
                push_byte(b);
                repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(255)));
            end
            1: begin
                add_record(1'b1);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(255)));
            end
            2: begin
                start = text_stream.size();
                add_record(1'b0);
                cut = $urandom_range(1, text_stream.size() - start);
                repeat (cut) text_stream.delete(text_stream.size() - 1);
            end
            3: begin
                push_byte(CH_CR);
                if ($urandom_range(1)) push_byte(any_but_lf());
            end
            default: ;
        endcase
        push_eos();
    endtask

    // receiver side, with one long hold-off early on
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready) seen_requests++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && seen_requests >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int idle;

        // blank crlf line, tab in header, lone cr in sequence, quality cut by end of stream
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_AT);
        push_byte("a");
        push_byte(CH_TAB);
        push_byte("z");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte("C");
        push_byte(CH_CR);
        push_byte("G");
        push_byte(CH_LF);
        push_byte(CH_PLUS);
        push_byte(CH_LF);
        push_byte("I");
        push_eos();
        // extreme id bytes, fasta sequence ending in a held cr
        push_byte(CH_GT);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CH_LF);
        push_byte("A");
        push_byte(CH_CR);
        push_eos();
        // bad header, then an ignored byte
        push_byte("x");
        push_byte(CH_AT);
        push_eos();

        while (text_stream.size() < STREAM_LEN) add_stream();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (text_stream[i]) begin
            case (i * 4 / text_stream.size())
                0: begin
                    idle = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle = 45;
                    stall_pct <= 0;
                end
                2: begin
                    idle = 0;
                    stall_pct <= 45;
                end
                default: begin
                    idle = 34;
                    stall_pct <= 34;
                end
            endcase
            while ($urandom_range(99) < idle) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= text_stream[i];
            do @(posedge aclk); while (!s_ready);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
